### rtl/slms_pkg.sv
// Package for the sparse LED matrix pixel scanner.
// Holds the matrix geometry, field widths, register indexes and the sequencer state type.
// No dependencies.
package slms_pkg;

  localparam int ROW_CNT    = 5;
  localparam int COL_CNT    = 8;
  localparam int ROW_STRIDE = 8;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int START_W    = COL_W + 1;
  localparam int PAT_W      = 40;
  localparam int INT_W      = 8;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 40;

  localparam logic [PAT_W-1:0] PATTERN_RST  = 40'hFF_2418_24FF;
  localparam logic [INT_W-1:0] INTERVAL_RST = 8'd1;

  typedef enum logic {
    REG_PATTERN  = 1'b0,
    REG_INTERVAL = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_FIN
  } scan_state_e;

endpackage

### rtl/sparse_led_matrix_pixel_scanner_unit.sv
// Sparse LED matrix pixel scanner: one row searched per cycle by a shared masked priority
// encoder. An item passes accept, deadline compare, a row search over the matrix rows
// (skipped if the deadline has not passed) and output load, and waits while the output
// register stays full and untaken. A new item is accepted only once the last is finished.
// Reset (async, active low): deadline and position zero, rows off, columns high,
// pattern and tick interval at their register reset values, no result pending.
module sparse_led_matrix_pixel_scanner_unit
  import slms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TIME_W-1:0]  time_now_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ROW_CNT-1:0] row_levels_o,
  output logic [COL_CNT-1:0] column_levels_o,
  output logic [ROW_W-1:0]   active_row_o,
  output logic [COL_W-1:0]   active_column_o,
  output logic               advanced_o
);

  scan_state_e state_q, state_d;

  logic [PAT_W-1:0]   pattern_q;
  logic [INT_W-1:0]   interval_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  deadline_q;
  logic [ROW_W-1:0]   row_pos_q;
  logic [COL_W-1:0]   col_pos_q;
  logic [ROW_CNT-1:0] row_pins_q;
  logic [COL_CNT-1:0] col_pins_q;
  logic               adv_q;
  logic               new_row_q;
  logic [ROW_W-1:0]   scan_row_q;
  logic [ROW_W-1:0]   scan_cnt_q;

  logic               out_valid_q;
  logic [ROW_CNT-1:0] out_rows_q;
  logic [COL_CNT-1:0] out_cols_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic               out_adv_q;

  logic               in_fire;
  logic               passed;
  logic               out_free;
  logic               last_row;
  logic               hit;
  logic [COL_W-1:0]   hit_col;
  logic [START_W-1:0] start_col;
  logic [COL_CNT-1:0] lit;
  logic [COL_CNT-1:0] row_bits [ROW_CNT];

  for (genvar r = 0; r < ROW_CNT; r++) begin : g_rows
    assign row_bits[r] = pattern_q[r*ROW_STRIDE +: COL_CNT];
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign passed   = deadline_q < now_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign last_row = scan_cnt_q == ROW_W'(ROW_CNT - 1);

  // Shared search unit: mask columns before the start, take the lowest lit one.
  always_comb begin
    start_col = (scan_cnt_q == '0) ? ({1'b0, col_pos_q} + START_W'(1)) : '0;
    hit_col   = '0;
    for (int c = 0; c < COL_CNT; c++) begin
      lit[c] = row_bits[scan_row_q][c] && (START_W'(c) >= start_col);
    end
    for (int c = COL_CNT - 1; c >= 0; c--) begin
      if (lit[c]) hit_col = COL_W'(c);
    end
    hit = |lit;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = passed ? ST_SCAN : ST_FIN;
      ST_SCAN: if (hit || last_row) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= PATTERN_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN:  pattern_q  <= cfg_data_i[PAT_W-1:0];
        REG_INTERVAL: interval_q <= cfg_data_i[INT_W-1:0];
        default:      pattern_q  <= pattern_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      row_pos_q  <= '0;
      col_pos_q  <= '0;
      row_pins_q <= '0;
      col_pins_q <= '1;
      adv_q      <= 1'b0;
      new_row_q  <= 1'b0;
      scan_row_q <= '0;
      scan_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          adv_q <= 1'b0;
        end
        ST_CMP: begin
          if (passed) begin
            adv_q                 <= 1'b1;
            deadline_q            <= now_q + TIME_W'(interval_q);
            col_pins_q[col_pos_q] <= 1'b1;
            new_row_q             <= 1'b0;
            scan_row_q            <= row_pos_q;
            scan_cnt_q            <= '0;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            row_pos_q           <= scan_row_q;
            col_pos_q           <= hit_col;
            col_pins_q[hit_col] <= 1'b0;
            if (new_row_q) row_pins_q[scan_row_q] <= 1'b1;
          end else if (last_row) begin
            // Nothing lit: position holds, old row ends enabled, old column low again.
            row_pins_q[row_pos_q] <= 1'b1;
            col_pins_q[col_pos_q] <= 1'b0;
          end else begin
            row_pins_q[row_pos_q] <= 1'b0;
            new_row_q             <= 1'b1;
            scan_cnt_q            <= scan_cnt_q + ROW_W'(1);
            scan_row_q            <= (scan_row_q == ROW_W'(ROW_CNT - 1)) ? '0
                                     : scan_row_q + ROW_W'(1);
          end
        end
        ST_FIN: begin
          adv_q <= adv_q;
        end
        default: adv_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) now_q <= time_now_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_rows_q <= row_pins_q;
      out_cols_q <= col_pins_q;
      out_row_q  <= row_pos_q;
      out_col_q  <= col_pos_q;
      out_adv_q  <= adv_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign row_levels_o    = out_rows_q;
  assign column_levels_o = out_cols_q;
  assign active_row_o    = out_row_q;
  assign active_column_o = out_col_q;
  assign advanced_o      = out_adv_q;

endmodule

### rtl/slms_chk.sv
// Port-level checker for the sparse LED matrix pixel scanner, bound to the top level.
// Depends on slms_pkg for the matrix geometry and field widths.
module slms_chk
  import slms_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [ROW_CNT-1:0] row_levels_o,
  input logic [COL_CNT-1:0] column_levels_o,
  input logic [ROW_W-1:0]   active_row_o,
  input logic [COL_W-1:0]   active_column_o,
  input logic               advanced_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(column_levels_o)
      && $stable(row_levels_o) && $stable(active_row_o) && $stable(active_column_o))
    else $error("stalled result changed");

  // Only one item in flight: ready drops after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  // At most one column of a valid result is driven low.
  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones(column_levels_o) >= COL_CNT - 1)
    else $error("more than one column enabled");

  // After a step the shown column is the enabled one, in a valid row.
  a_step_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && advanced_o |-> !column_levels_o[active_column_o]
      && active_row_o < ROW_W'(ROW_CNT))
    else $error("active column not enabled after step");

endmodule

bind sparse_led_matrix_pixel_scanner_unit slms_chk u_slms_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .row_levels_o    (row_levels_o),
  .column_levels_o (column_levels_o),
  .active_row_o    (active_row_o),
  .active_column_o (active_column_o),
  .advanced_o      (advanced_o)
);
